/* src/vtp_pkg.sv */
`default_nettype none
package vtp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ACC_W     = 66 - FRAC_BITS;
  localparam int NUM_W     = ACC_W + FRAC_BITS;
  localparam int QBITS     = 33;
  localparam int HI_W      = NUM_W - QBITS;
  localparam int NUM_REGS  = 8;
  localparam int IDX_W     = 4;

  localparam logic [1:0] OP_ROW_POINT = 2'd0;
  localparam logic [1:0] OP_ROW_DIR   = 2'd1;
  localparam logic [1:0] OP_COL_POINT = 2'd2;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  localparam logic [IDX_W-1:0] REG_R0_C01 = 4'd0;
  localparam logic [IDX_W-1:0] REG_R0_C23 = 4'd1;
  localparam logic [IDX_W-1:0] REG_R1_C01 = 4'd2;
  localparam logic [IDX_W-1:0] REG_R1_C23 = 4'd3;
  localparam logic [IDX_W-1:0] REG_R2_C01 = 4'd4;
  localparam logic [IDX_W-1:0] REG_R2_C23 = 4'd5;
  localparam logic [IDX_W-1:0] REG_R3_C01 = 4'd6;
  localparam logic [IDX_W-1:0] REG_R3_C23 = 4'd7;

  localparam logic [63:0] FX_ONE_LO = 64'(1) << FRAC_BITS;
  localparam logic [63:0] FX_ONE_HI = FX_ONE_LO << 32;

  typedef struct packed {
    logic [ACC_W-1:0] rem;
    logic [QBITS-1:0] lo;
  } div_lane_t;

  typedef struct packed {
    logic [1:0]            op;
    logic                  divide;
    logic                  skipped;
    logic [2:0]            ovf;
    logic [2:0]            neg;
    logic [ACC_W-1:0]      ad;
    logic [2:0][ACC_W-1:0] acc;
    div_lane_t [2:0]       lane;
  } div_item_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        skipped;
    logic        sat;
  } res_t;

endpackage
`default_nettype wire

/* src/vtp_if.sv */
`default_nettype none
interface vtp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [31:0] in_z;
  modport source (output valid, operation, in_x, in_y, in_z, input ready);
  modport sink (input valid, operation, in_x, in_y, in_z, output ready);
endinterface

interface vtp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               divide_skipped;
  logic               saturated;
  modport source (output valid, out_x, out_y, out_z, divide_skipped, saturated,
                  input ready);
  modport sink (input valid, out_x, out_y, out_z, divide_skipped, saturated,
                output ready);
endinterface
`default_nettype wire

/* src/vtp_div_stage.sv */
`default_nettype none
module vtp_div_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_v,
  input  wire vtp_pkg::div_item_t in_d,
  output logic                   out_v,
  output vtp_pkg::div_item_t     out_d
);
  import vtp_pkg::*;

  logic      out_v_r;
  div_item_t out_d_r;
  div_item_t step_nxt;
  logic [ACC_W:0] trial;

  always_comb begin
    step_nxt = in_d;
    trial = '0;
    for (int k = 0; k < 3; k++) begin
      trial = {in_d.lane[k].rem, in_d.lane[k].lo[QBITS-1]};
      if (trial >= {1'b0, in_d.ad}) begin
        step_nxt.lane[k].rem = ACC_W'(trial - {1'b0, in_d.ad});
        step_nxt.lane[k].lo  = {in_d.lane[k].lo[QBITS-2:0], 1'b1};
      end else begin
        step_nxt.lane[k].rem = trial[ACC_W-1:0];
        step_nxt.lane[k].lo  = {in_d.lane[k].lo[QBITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d_r <= step_nxt;
    end
  end

  assign out_v = out_v_r;
  assign out_d = out_d_r;
endmodule
`default_nettype wire

/* src/vertex_transform_perspective.sv */
`default_nettype none
// channel   dir  payload                                            request when
// in_ch     in   operation, in_x, in_y, in_z                        valid && ready
// out_ch    out  out_x, out_y, out_z, divide_skipped, saturated     valid && ready
// cfg_*     in   cfg_idx, cfg_data (8 x 64-bit matrix registers)    cfg_we
//
// one request per cycle sustained while the skid entry is empty; a request passes through input,
// product, sum, divide setup, one quotient bit per divider stage and output register
// the 33 divider stages set the depth; items overlap freely
// rst_n clears valid bits and loads the identity matrix
// a two-entry output buffer stalls the whole pipeline only when both entries are full
module vertex_transform_perspective (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  vtp_in_if.sink                         in_ch,
  vtp_out_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [vtp_pkg::IDX_W-1:0] cfg_idx,
  input  wire logic [63:0]               cfg_data
);
  import vtp_pkg::*;

  logic [63:0] mat_r [NUM_REGS];

  logic en;
  logic skid_v_r, out_v_r;
  res_t skid_r, out_r, res_nxt;

  logic               v0_r;
  logic [1:0]         op0_r;
  logic signed [31:0] vec_r [3];

  logic               v1_r;
  logic [1:0]         op1_r;
  logic signed [63:0] prod_r [4][3];
  logic signed [63:0] prod_nxt [4][3];
  logic signed [31:0] cst_r [4];
  logic signed [31:0] cst_nxt [4];

  logic               v2_r;
  logic [1:0]         op2_r;
  logic signed [ACC_W-1:0] acc_r [4];
  logic signed [ACC_W-1:0] acc_nxt [4];

  logic      dv [QBITS+1];
  div_item_t dq [QBITS+1];
  div_item_t setup_nxt;

  function automatic logic signed [31:0] elem(input logic [1:0] r, input logic [1:0] c);
    logic [63:0] word;
    word = mat_r[{r, c[1]}];
    return c[0] ? $signed(word[63:32]) : $signed(word[31:0]);
  endfunction

  function automatic logic [31:0] clamp(input logic signed [ACC_W-1:0] v,
                                        output logic sat);
    logic signed [ACC_W-1:0] hi, lo;
    hi = $signed({{(ACC_W-32){1'b0}}, 32'h7fff_ffff});
    lo = $signed({{(ACC_W-32){1'b1}}, 32'h8000_0000});
    sat = 1'b0;
    if (v > hi) begin
      sat = 1'b1;
      return 32'h7fff_ffff;
    end else if (v < lo) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  assign en = !skid_v_r;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r[0] <= FX_ONE_LO;
      mat_r[1] <= '0;
      mat_r[2] <= FX_ONE_HI;
      mat_r[3] <= '0;
      mat_r[4] <= '0;
      mat_r[5] <= FX_ONE_LO;
      mat_r[6] <= '0;
      mat_r[7] <= FX_ONE_HI;
    end else if (cfg_we && cfg_idx <= REG_R3_C23) begin
      mat_r[cfg_idx[2:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      dv[0] <= 1'b0;
    end else if (en) begin
      v0_r <= in_ch.valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      dv[0] <= v2_r;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 3; j++) begin
        if (op0_r == OP_COL_POINT) begin
          prod_nxt[k][j] = 64'(vec_r[j]) * 64'(elem(2'(k), 2'(j)));
        end else begin
          prod_nxt[k][j] = 64'(vec_r[j]) * 64'(elem(2'(j), 2'(k)));
        end
      end
      case (op0_r)
        OP_COL_POINT: cst_nxt[k] = elem(2'(k), 2'd3);
        OP_ROW_POINT: cst_nxt[k] = elem(2'd3, 2'(k));
        default:      cst_nxt[k] = '0;
      endcase
    end
  end

  always_comb begin
    logic signed [63:0] s;
    for (int k = 0; k < 4; k++) begin
      s = (prod_r[k][0] >>> FRAC_BITS) + (prod_r[k][1] >>> FRAC_BITS)
        + (prod_r[k][2] >>> FRAC_BITS) + 64'(cst_r[k]);
      acc_nxt[k] = s[ACC_W-1:0];
    end
  end

  always_comb begin
    logic [ACC_W-1:0] an;
    logic [NUM_W-1:0] num;
    logic             wz;
    wz = (acc_r[3] == '0);
    setup_nxt = '0;
    setup_nxt.op = op2_r;
    setup_nxt.divide = (op2_r == OP_ROW_POINT || op2_r == OP_COL_POINT) && !wz;
    setup_nxt.skipped = (op2_r == OP_ROW_POINT || op2_r == OP_COL_POINT) && wz;
    setup_nxt.ad = acc_r[3][ACC_W-1] ? ACC_W'(-acc_r[3]) : acc_r[3];
    for (int k = 0; k < 3; k++) begin
      setup_nxt.acc[k] = acc_r[k];
      an = acc_r[k][ACC_W-1] ? ACC_W'(-acc_r[k]) : acc_r[k];
      num = {an, {FRAC_BITS{1'b0}}};
      setup_nxt.neg[k] = acc_r[k][ACC_W-1] ^ acc_r[3][ACC_W-1];
      setup_nxt.ovf[k] = ACC_W'(num[NUM_W-1:QBITS]) >= setup_nxt.ad;
      setup_nxt.lane[k].rem = ACC_W'(num[NUM_W-1:QBITS]);
      setup_nxt.lane[k].lo  = num[QBITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op0_r <= in_ch.operation;
      vec_r[0] <= in_ch.in_x;
      vec_r[1] <= in_ch.in_y;
      vec_r[2] <= in_ch.in_z;
      op1_r <= op0_r;
      prod_r <= prod_nxt;
      cst_r <= cst_nxt;
      op2_r <= op1_r;
      acc_r <= acc_nxt;
      dq[0] <= setup_nxt;
    end
  end

  for (genvar i = 0; i < QBITS; i++) begin : g_div
    vtp_div_stage u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .in_v  (dv[i]),
      .in_d  (dq[i]),
      .out_v (dv[i+1]),
      .out_d (dq[i+1])
    );
  end

  always_comb begin
    logic signed [ACC_W-1:0] v;
    logic [2:0]  sat;
    logic [31:0] c [3];
    div_item_t   d;
    d = dq[QBITS];
    for (int k = 0; k < 3; k++) begin
      if (d.divide) begin
        if (d.ovf[k]) begin
          v = d.neg[k] ? $signed({{(ACC_W-34){1'b1}}, 34'h3_0000_0000})
                       : $signed({{(ACC_W-34){1'b0}}, 34'h1_0000_0000});
        end else begin
          v = $signed({{(ACC_W-QBITS){1'b0}}, d.lane[k].lo});
          if (d.neg[k]) begin
            v = -v;
          end
        end
      end else begin
        v = $signed(d.acc[k]);
      end
      c[k] = clamp(v, sat[k]);
    end
    if (d.op == OP_ROW_POINT || d.op == OP_ROW_DIR || d.op == OP_COL_POINT) begin
      res_nxt.x = c[0];
      res_nxt.y = c[1];
      res_nxt.z = c[2];
      res_nxt.skipped = d.skipped;
      res_nxt.sat = |sat;
    end else begin
      res_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      if (skid_v_r) begin
        out_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= dv[QBITS];
      end
    end else if (en && dv[QBITS]) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ch.ready) begin
      out_r <= skid_v_r ? skid_r : res_nxt;
    end else if (en && dv[QBITS]) begin
      skid_r <= res_nxt;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.out_x = out_r.x;
  assign out_ch.out_y = out_r.y;
  assign out_ch.out_z = out_r.z;
  assign out_ch.divide_skipped = out_r.skipped;
  assign out_ch.saturated = out_r.sat;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid entry without output entry");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_ch.ready))
    else $error("skid filled without output stall");

  a_valid_moves: assert property (@(posedge clk) disable iff (!rst_n)
    en && v1_r |=> v2_r) else $error("request lost between product and sum");

  a_dir_no_skip: assert property (@(posedge clk) disable iff (!rst_n)
    dv[QBITS] && dq[QBITS].op == OP_ROW_DIR |-> !dq[QBITS].skipped && !dq[QBITS].divide)
    else $error("direction request marked for divide");
endmodule
`default_nettype wire
